// ===== hdl/hht_pkg.sv =====
package hht_pkg;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} hht_cmd_t;

	typedef struct packed {
		logic scan_last;
	} hht_sts_t;

endpackage

// ===== hdl/hht_ctrl.sv =====
module hht_ctrl
	import hht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  hht_sts_t sts,
	output hht_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DECIDE);
		end
	end

	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_DECIDE);
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;

endmodule

// ===== hdl/hht_datapath.sv =====
module hht_datapath
	import hht_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hht_cmd_t    cmd,
	output hht_sts_t    sts,
	input  logic        kind,
	input  logic [31:0] key,
	input  logic [31:0] estimate,
	output logic [31:0] out_count,
	output logic        hit,
	output logic        installed
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [31:0] keys_mem   [TABLE_ENTRIES];
	logic [31:0] counts_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          kind_q;
	logic [31:0]   key_q;
	logic [31:0]   est_q;
	logic [IW-1:0] scan_idx_q;

	logic          rd_en_s1;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   rd_key_s1;
	logic [31:0]   rd_cnt_s1;

	logic          found_q;
	logic [IW-1:0] match_idx_q;
	logic [31:0]   match_cnt_q;
	logic [IW-1:0] low_idx_q;
	logic [31:0]   low_cnt_q;

	logic [31:0]   out_count_q;
	logic          hit_q;
	logic          installed_q;

	logic [31:0]   eff_key;
	logic [31:0]   eff_cnt;
	logic          inst_c;
	logic          wr_en;
	logic [IW-1:0] wr_idx;

	// entries never written read as the cleared value
	assign eff_key = rd_vld_s1 ? rd_key_s1 : 32'd0;
	assign eff_cnt = rd_vld_s1 ? rd_cnt_s1 : 32'd0;

	assign inst_c = !found_q && (est_q > low_cnt_q);
	assign wr_en  = cmd.commit && ((found_q && (kind_q == KIND_UPDATE)) || inst_c);
	assign wr_idx = found_q ? match_idx_q : low_idx_q;

	assign sts.scan_last = (scan_idx_q == IW'(TABLE_ENTRIES - 1));

	always_ff @(posedge clk) begin
		rd_key_s1 <= keys_mem[scan_idx_q];
		rd_cnt_s1 <= counts_mem[scan_idx_q];
		if (wr_en) begin
			keys_mem[wr_idx]   <= key_q;
			counts_mem[wr_idx] <= est_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			scan_idx_q <= '0;
			rd_en_s1   <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan;
			if (cmd.load) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (cmd.scan && !sts.scan_last) scan_idx_q <= scan_idx_q + IW'(1);
				if (rd_en_s1 && !found_q && (eff_key == key_q)) found_q <= 1'b1;
			end
			if (wr_en) valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[scan_idx_q];
		rd_idx_s1 <= scan_idx_q;
		if (cmd.load) begin
			kind_q    <= kind;
			key_q     <= key;
			est_q     <= estimate;
			low_cnt_q <= COUNT_MAX;
			low_idx_q <= '0;
		end else if (rd_en_s1) begin
			// keep the first match and the first strictly smallest count
			if (!found_q && (eff_key == key_q)) begin
				match_idx_q <= rd_idx_s1;
				match_cnt_q <= eff_cnt;
			end
			if (eff_cnt < low_cnt_q) begin
				low_cnt_q <= eff_cnt;
				low_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.commit) begin
			out_count_q <= (found_q && (kind_q == KIND_QUERY)) ? match_cnt_q : est_q;
			hit_q       <= found_q;
			installed_q <= inst_c;
		end
	end

	assign out_count = out_count_q;
	assign hit       = hit_q;
	assign installed = installed_q;

endmodule

// ===== hdl/heavy_hitter_table_unit.sv =====
// From the accepting edge the unit scans every table entry, then passes the drain and decide states before done.
// A new item is taken only once the previous one is finished, as the scan reads one table entry
//   per cycle through the single read port.
// done pulses for one cycle with the result; the receiver cannot stall it.
// Reset: arst_n clears the controller and all entry valid bits; the table reads as all zero.
module heavy_hitter_table_unit
	import hht_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] key,
	input  logic [31:0] estimate,
	output logic        done,
	output logic [31:0] out_count,
	output logic        hit,
	output logic        installed
);

	hht_cmd_t cmd;
	hht_sts_t sts;

	hht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	hht_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.key       (key),
		.estimate  (estimate),
		.out_count (out_count),
		.hit       (hit),
		.installed (installed)
	);

endmodule

// ===== hdl/hht_checker.sv =====
module hht_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hit,
	input logic installed
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an item was taken");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_hit_no_install: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !installed)
		else $error("installed flagged on a hit");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result right after accepting an item");

endmodule

bind heavy_hitter_table_unit hht_checker u_hht_checker (.*);
